@@ rtl/key_scan_event_generator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Key scan event generator - assertion macros
// Shared assertion forms for the key scan event generator.
// ----------------------------------------------------------------------------
`ifndef KEY_SCAN_EVENT_GENERATOR_TOP_DEFINES_SVH
`define KEY_SCAN_EVENT_GENERATOR_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define KSG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property that must never hold on a rising clock edge outside reset.
`define KSG_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("%m: forbidden condition seen");

`endif

@@ rtl/ksg_pkg.sv @@
// ----------------------------------------------------------------------------
// Key scan event generator package
// Widths, slot layout and event codes shared by the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ksg_pkg;

  // Number of keys in one scan row.
  localparam int unsigned KEY_COUNT = 12;

  // Field widths of the output beat.
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned OCTAVE_W  = 4;
  localparam int unsigned KEY_NUM_W = 4;

  // Event slots: one per key, then speaker, mute and handshake.
  localparam int unsigned SLOT_SPK   = KEY_COUNT;
  localparam int unsigned SLOT_MUTE  = KEY_COUNT + 1;
  localparam int unsigned SLOT_HS    = KEY_COUNT + 2;
  localparam int unsigned EVT_COUNT  = KEY_COUNT + 3;
  localparam int unsigned IDX_W      = $clog2(EVT_COUNT);

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS     = 3'd0,
    KIND_RELEASE   = 3'd1,
    KIND_SPEAKER   = 3'd2,
    KIND_UNMUTE    = 3'd3,
    KIND_MUTE      = 3'd4,
    KIND_HANDSHAKE = 3'd5
  } event_kind_e;

  typedef logic [EVT_COUNT-1:0] slot_vec_t;

endpackage : ksg_pkg

`default_nettype wire

@@ rtl/key_scan_event_generator_top.sv @@
// ----------------------------------------------------------------------------
// Key scan event generator
// Turns one completed key-matrix scan into a run of key, knob and
// neighbour handshake events, one event beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat contents
//   -------  ---------  ---------------------  --------------------------------
//   in       input      in_valid_i/in_ready_o  one scan: keys, knobs, detect,
//                                              octave
//   out      output     out_valid_o/out_ready_i one event with kind, octave,
//                                              key number and last flag
//
// A scan beat produces between zero and KEY_COUNT + 3 event beats, which are
// delivered one per cycle from the pending-event register while the output
// is not stalled.
// The next scan is taken in the same cycle in which the final event of the
// current one moves into the output register.
// Reset clears all history to "all keys released, buttons low, not muted,
// no baseline" and drops any pending or buffered events.
// A stall on the output holds the output register and the pending set.
//
`timescale 1ns / 1ps
`default_nettype none

`include "key_scan_event_generator_top_defines.svh"

module key_scan_event_generator_top
  import ksg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [KEY_COUNT-1:0] key_bits_i,
  input  wire logic                 speaker_button_i,
  input  wire logic                 mute_button_i,
  input  wire logic                 west_detect_i,
  input  wire logic                 east_detect_i,
  input  wire logic [OCTAVE_W-1:0]  octave_now_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [KIND_W-1:0]         event_kind_o,
  output logic [OCTAVE_W-1:0]       event_octave_o,
  output logic [KEY_NUM_W-1:0]      key_number_o,
  output logic                      last_event_o
);

  // --------------------------------------------------------------------------
  // Scan history. All of it is updated at the moment a scan is accepted,
  // since every decision depends only on the new scan and the old history.
  // --------------------------------------------------------------------------
  logic [KEY_COUNT-1:0] last_keys_q;
  logic                 last_spk_q;
  logic                 last_mute_q;
  logic                 muted_q;
  logic                 speaker_master_q;
  logic                 baseline_taken_q;
  logic                 west_base_q;
  logic                 east_base_q;
  logic                 hs_reported_q;

  // Pending events of the scan being delivered, one bit per slot, plus the
  // scan payload needed to fill in those events.
  slot_vec_t            pend_q;
  slot_vec_t            pend_d;
  logic [KEY_COUNT-1:0] keys_q;
  logic [OCTAVE_W-1:0]  oct_q;
  logic                 mute_kind_q;

  // Output register.
  logic                 out_valid_q;
  event_kind_e          kind_q;
  event_kind_e          kind_d;
  logic [OCTAVE_W-1:0]  evt_oct_q;
  logic [OCTAVE_W-1:0]  evt_oct_d;
  logic [KEY_NUM_W-1:0] key_num_q;
  logic [KEY_NUM_W-1:0] key_num_d;
  logic                 last_q;

  logic                 in_fire;
  logic                 pend_any;
  logic                 out_load;
  logic                 pop;
  logic                 pop_last;
  slot_vec_t            lowest;
  slot_vec_t            rest;
  logic [IDX_W-1:0]     idx;
  logic                 is_key;
  logic                 key_level;

  // New-scan event detection.
  logic [KEY_COUNT-1:0] key_diff;
  logic                 west_pres;
  logic                 east_pres;
  logic                 spk_ev;
  logic                 mute_ev;
  logic                 hs_ev;
  slot_vec_t            new_slots;

  // --------------------------------------------------------------------------
  // Handshake control. The output register takes a new event whenever it is
  // empty or its current beat leaves this cycle. A scan is accepted when the
  // pending set is empty or its final event is popped in this cycle.
  // --------------------------------------------------------------------------
  assign pend_any   = |pend_q;
  assign out_load   = !out_valid_q || out_ready_i;
  assign pop        = pend_any && out_load;
  assign in_ready_o = !pend_any || (pop && pop_last);
  assign in_fire    = in_valid_i && in_ready_o;

  // Presence is the inverse of the raw detect level.
  assign west_pres = ~west_detect_i;
  assign east_pres = ~east_detect_i;

  assign key_diff = key_bits_i ^ last_keys_q;
  assign spk_ev   = speaker_button_i && !last_spk_q;
  assign mute_ev  = mute_button_i && !last_mute_q;
  // On the very first scan the baseline equals the current presence, so it
  // can never report a change.
  assign hs_ev    = !hs_reported_q && baseline_taken_q &&
                    ((west_pres != west_base_q) || (east_pres != east_base_q));

  always_comb begin
    new_slots                       = '0;
    new_slots[KEY_COUNT-1:0]        = key_diff;
    new_slots[SLOT_SPK]             = spk_ev;
    new_slots[SLOT_MUTE]            = mute_ev;
    new_slots[SLOT_HS]              = hs_ev;
  end

  // --------------------------------------------------------------------------
  // Event selection: the lowest pending slot goes out next, which gives key
  // events in ascending order followed by speaker, mute and handshake.
  // --------------------------------------------------------------------------
  assign lowest   = pend_q & (~pend_q + slot_vec_t'(1));
  assign rest     = pend_q & ~lowest;
  assign pop_last = (rest == '0);

  always_comb begin
    idx = '0;
    for (int i = 0; i < EVT_COUNT; i++) begin
      if (lowest[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  assign is_key    = |lowest[KEY_COUNT-1:0];
  // A set key bit means the key is now released.
  assign key_level = |(lowest[KEY_COUNT-1:0] & keys_q);

  always_comb begin
    kind_d    = KIND_HANDSHAKE;
    evt_oct_d = '0;
    key_num_d = '0;
    if (is_key) begin
      kind_d    = key_level ? KIND_RELEASE : KIND_PRESS;
      evt_oct_d = oct_q;
      key_num_d = KEY_NUM_W'({1'b0, idx} + (IDX_W + 1)'(1));
    end else if (lowest[SLOT_SPK]) begin
      kind_d = KIND_SPEAKER;
    end else if (lowest[SLOT_MUTE]) begin
      kind_d = mute_kind_q ? KIND_MUTE : KIND_UNMUTE;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (pop) begin
      pend_d = rest;
    end
    if (in_fire) begin
      pend_d = new_slots;
    end
  end

  // --------------------------------------------------------------------------
  // Control and history registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_keys_q      <= '1;
      last_spk_q       <= 1'b0;
      last_mute_q      <= 1'b0;
      muted_q          <= 1'b0;
      speaker_master_q <= 1'b0;
      baseline_taken_q <= 1'b0;
      west_base_q      <= 1'b0;
      east_base_q      <= 1'b0;
      hs_reported_q    <= 1'b0;
      pend_q           <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= pend_any;
      end
      if (in_fire) begin
        last_keys_q <= key_bits_i;
        last_spk_q  <= speaker_button_i;
        last_mute_q <= mute_button_i;
        if (spk_ev) begin
          speaker_master_q <= 1'b1;
        end
        if (mute_ev) begin
          muted_q <= ~muted_q;
        end
        if (!baseline_taken_q) begin
          baseline_taken_q <= 1'b1;
          west_base_q      <= west_pres;
          east_base_q      <= east_pres;
        end
        if (hs_ev) begin
          hs_reported_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers: scan data for the pending set and the output beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      keys_q      <= key_bits_i;
      oct_q       <= octave_now_i;
      // A mute-button edge mutes when the block is currently unmuted.
      mute_kind_q <= ~muted_q;
    end
    if (pop) begin
      kind_q    <= kind_d;
      evt_oct_q <= evt_oct_d;
      key_num_q <= key_num_d;
      last_q    <= pop_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign event_octave_o = evt_oct_q;
  assign key_number_o   = key_num_q;
  assign last_event_o   = last_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `KSG_ASSERT(a_key_number_range, clk_i, rst_ni,
    (out_valid_q && (kind_q == KIND_PRESS || kind_q == KIND_RELEASE)) |->
      (key_num_q != '0 && key_num_q <= KEY_NUM_W'(KEY_COUNT)))
  `KSG_ASSERT(a_knob_event_clean, clk_i, rst_ni,
    (out_valid_q && kind_q != KIND_PRESS && kind_q != KIND_RELEASE) |->
      (key_num_q == '0 && evt_oct_q == '0))
  `KSG_ASSERT(a_run_ends_clean, clk_i, rst_ni,
    (pop && pop_last && !in_fire) |=> (!pend_any && last_q))
  `KSG_ASSERT_NEVER(a_handshake_without_scan, clk_i, rst_ni,
    $rose(hs_reported_q) && !$past(in_fire))
  // Once a speaker select has been seen, this block stays the speaker master.
  `KSG_ASSERT(a_speaker_master_sticky, clk_i, rst_ni,
    speaker_master_q |=> speaker_master_q)

endmodule : key_scan_event_generator_top

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Key scan event generator testbench
// Sends key-matrix scan beats into the generator and checks every event beat
// against an in-bench prediction of key, knob and neighbour handshake events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ksg_pkg::*;

  // Cycles without any accepted beat on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settling time after the last expected event has arrived.
  localparam int TAIL_CYCLES    = 32;
  localparam int MAX_PRINTS     = 50;

  localparam logic [KEY_COUNT-1:0] ALL_RELEASED = '1;
  localparam logic [KEY_COUNT-1:0] ALL_PRESSED  = '0;

  // One predicted event beat.
  typedef struct packed {
    event_kind_e             kind;
    logic [OCTAVE_W-1:0]     octave;
    logic [KEY_NUM_W-1:0]    key_num;
    logic                    last_flag;
  } key_evt_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KEY_COUNT-1:0]  key_bits = ALL_RELEASED;
  logic                  speaker_button = 1'b0;
  logic                  mute_button = 1'b0;
  logic                  west_detect = 1'b1;
  logic                  east_detect = 1'b1;
  logic [OCTAVE_W-1:0]   octave_now = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [KIND_W-1:0]     event_kind;
  logic [OCTAVE_W-1:0]   event_octave;
  logic [KEY_NUM_W-1:0]  key_number;
  logic                  last_event;

  // Events predicted but not yet seen on the output, oldest first.
  key_evt_t              pending_events[$];
  int                    err_count = 0;

  // Idling controls, switched per test phase.
  bit                    send_idle_en = 1'b0;
  bit                    recv_idle_en = 1'b0;
  int                    recv_stall_left = 0;
  int                    quiet_cycles = 0;

  // Predictor copy of the generator history.
  logic [KEY_COUNT-1:0]  seen_keys = ALL_RELEASED;
  logic                  seen_spk = 1'b0;
  logic                  seen_mute = 1'b0;
  logic                  muted_now = 1'b0;
  logic                  baseline_valid = 1'b0;
  logic                  west_base = 1'b0;
  logic                  east_base = 1'b0;
  logic                  hs_done = 1'b0;

  // Levels of the last scan sent, used to build random scans that mostly
  // differ from their predecessor in a few bits only.
  logic [KEY_COUNT-1:0]  cur_keys = ALL_RELEASED;
  logic                  cur_spk = 1'b0;
  logic                  cur_mute = 1'b0;

  key_scan_event_generator_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .key_bits_i       (key_bits),
    .speaker_button_i (speaker_button),
    .mute_button_i    (mute_button),
    .west_detect_i    (west_detect),
    .east_detect_i    (east_detect),
    .octave_now_i     (octave_now),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .event_kind_o     (event_kind),
    .event_octave_o   (event_octave),
    .key_number_o     (key_number),
    .last_event_o     (last_event)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Work out the events one accepted scan causes and queue them in order:
  // changed keys in ascending order, then speaker select, then mute toggle,
  // then a single handshake change. The final one carries the last flag.
  function automatic void predict_scan(input logic [KEY_COUNT-1:0] keys,
                                       input logic spk, input logic mute,
                                       input logic west_raw,
                                       input logic east_raw,
                                       input logic [OCTAVE_W-1:0] oct);
    key_evt_t             run[$];
    key_evt_t             e;
    logic [KEY_COUNT-1:0] changed;
    logic                 west_here;
    logic                 east_here;
    changed   = keys ^ seen_keys;
    west_here = ~west_raw;
    east_here = ~east_raw;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (changed[i]) begin
        e.kind      = keys[i] ? KIND_RELEASE : KIND_PRESS;
        e.octave    = oct;
        e.key_num   = KEY_NUM_W'(i + 1);
        e.last_flag = 1'b0;
        run.push_back(e);
      end
    end
    seen_keys = keys;

    e.octave    = '0;
    e.key_num   = '0;
    e.last_flag = 1'b0;
    if (spk && !seen_spk) begin
      e.kind = KIND_SPEAKER;
      run.push_back(e);
    end
    seen_spk = spk;

    if (mute && !seen_mute) begin
      e.kind = muted_now ? KIND_UNMUTE : KIND_MUTE;
      muted_now = ~muted_now;
      run.push_back(e);
    end
    seen_mute = mute;

    // The very first scan sets the neighbour baseline, so it cannot differ.
    if (!baseline_valid) begin
      west_base      = west_here;
      east_base      = east_here;
      baseline_valid = 1'b1;
    end
    if (!hs_done && (west_here != west_base || east_here != east_base)) begin
      e.kind = KIND_HANDSHAKE;
      run.push_back(e);
      hs_done = 1'b1;
    end

    if (run.size() > 0) run[run.size() - 1].last_flag = 1'b1;
    foreach (run[i]) pending_events.push_back(run[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Present one scan beat and hold it until it is taken. Entered and left on
  // a rising edge. A random gap drops valid first; when there is no gap the
  // valid stays high straight into the next beat.
  task automatic send_scan(input logic [KEY_COUNT-1:0] keys, input logic spk,
                           input logic mute, input logic west_raw,
                           input logic east_raw, input logic [OCTAVE_W-1:0] oct);
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    key_bits       <= keys;
    speaker_button <= spk;
    mute_button    <= mute;
    west_detect    <= west_raw;
    east_detect    <= east_raw;
    octave_now     <= oct;
    do @(posedge clk_i); while (!in_ready);
    predict_scan(keys, spk, mute, west_raw, east_raw, oct);
    cur_keys = keys;
    cur_spk  = spk;
    cur_mute = mute;
  endtask

  // Hold off the sender until every predicted event has come out.
  task automatic drain_events;
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Output side: random stall bursts when enabled.
  always @(posedge clk_i) begin
    if (recv_stall_left > 0) begin
      recv_stall_left--;
      out_ready <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
      recv_stall_left = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted event beat is matched against the oldest prediction.
  always @(posedge clk_i) begin : check_events
    key_evt_t want;
    if (out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d octave %0d key %0d last %0b",
                                  event_kind, event_octave, key_number, last_event));
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind)
          report_mismatch($sformatf("event kind %0d, wanted %0d", event_kind, want.kind));
        if (event_octave !== want.octave)
          report_mismatch($sformatf("event octave %0d, wanted %0d",
                                    event_octave, want.octave));
        if (key_number !== want.key_num)
          report_mismatch($sformatf("key number %0d, wanted %0d", key_number, want.key_num));
        if (last_event !== want.last_flag)
          report_mismatch($sformatf("last flag %0b, wanted %0b", last_event, want.last_flag));
      end
    end
  end

  // Watchdog: a long run of cycles without any beat on either side means
  // the generator has hung.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // First scan after reset: nothing changes and it latches the neighbour
  // baseline (both neighbours absent), so no event at all is due.
  task automatic test_first_scan;
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0);
  endtask

  // Whole-row, single-key and alternating-key changes, including the octave extremes.
  task automatic test_key_extremes;
    send_scan(ALL_PRESSED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd15);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0);
    send_scan(12'hffe, 1'b0, 1'b0, 1'b1, 1'b1, 4'd5);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd5);
    send_scan(12'h7ff, 1'b0, 1'b0, 1'b1, 1'b1, 4'd9);
    send_scan(12'haaa, 1'b0, 1'b0, 1'b1, 1'b1, 4'd10);
    send_scan(12'h555, 1'b0, 1'b0, 1'b1, 1'b1, 4'd3);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd12);
  endtask

  // Knob buttons: only rising edges count; a held level stays silent and
  // the mute button alternates between mute and unmute.
  task automatic test_buttons;
    send_scan(ALL_RELEASED, 1'b1, 1'b0, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b1, 1'b0, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b1, 1'b0, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b0, 1'b1, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b0, 1'b1, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b0, 1'b1, 1'b1, 1'b1, 4'd1);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1);
  endtask

  // Longest run: every key, speaker, mute and the one handshake change in a
  // single scan. After that, neighbour changes stay silent until reset.
  task automatic test_handshake_full_run;
    send_scan(ALL_PRESSED, 1'b1, 1'b1, 1'b0, 1'b1, 4'd15);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b0, 4'd7);
    send_scan(ALL_RELEASED, 1'b0, 1'b0, 1'b1, 1'b0, 4'd7);
  endtask

  // Random scans. Most flip a few keys of the previous scan, as real
  // playing does; the rest repeat the scan, jump to a random row or hit a
  // whole-row extreme. Buttons toggle now and then so edges and holds mix.
  task automatic test_random_scans(input int count);
    logic [KEY_COUNT-1:0] keys;
    logic                 spk;
    logic                 mute;
    logic                 west_raw;
    logic                 east_raw;
    int                   mode;
    for (int n = 0; n < count; n++) begin
      keys = cur_keys;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        repeat ($urandom_range(1, 3)) keys[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
      end else if (mode == 7) begin
        keys = KEY_COUNT'($urandom);
      end else if (mode == 8) begin
        keys = $urandom_range(0, 1) ? ALL_PRESSED : ALL_RELEASED;
      end
      spk  = ($urandom_range(0, 9) < 3) ? ~cur_spk : cur_spk;
      mute = ($urandom_range(0, 9) < 3) ? ~cur_mute : cur_mute;
      if ($urandom_range(0, 9) == 0) begin
        west_raw = 1'($urandom_range(0, 1));
        east_raw = 1'($urandom_range(0, 1));
      end else begin
        west_raw = 1'b1;
        east_raw = 1'b0;
      end
      send_scan(keys, spk, mute, west_raw, east_raw, OCTAVE_W'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with both sides free of idling.
    test_first_scan();
    test_key_extremes();
    test_buttons();
    test_handshake_full_run();

    // Random part with idle bursts on both sides, broken by one full drain.
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    test_random_scans(90);
    drain_events();
    test_random_scans(70);

    // Closing stretch with no idling at all.
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random_scans(40);
    in_valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d predicted events never came out",
                                pending_events.size()));
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
